/* src/multi_channel_interval_timer_bank_assert.svh */
// assertion macros for the interval timer bank
`ifndef MULTI_CHANNEL_INTERVAL_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_INTERVAL_TIMER_BANK_ASSERT_SVH

// checked on every rising edge of clk, off while rst is high
`define MCITB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge of clk, reset included
`define MCITB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mcitb_pkg.sv */
// shared constants and types for the interval timer bank
package mcitb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int TIME_W      = 32;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = TIME_W / DIGIT_W;
  localparam int DCNT_W      = $clog2(NUM_DIGITS);
  localparam int IDX_W       = 3;
  localparam int MASK_W      = 8;

  localparam logic [TIME_W-1:0] COUNTER_PERIOD_RESET = 32'd1000000000;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

/* src/multi_channel_interval_timer_bank.sv */
// interval timer bank top level with digit-serial tick processing
//
// A set, start or stop item and the first tick after reset need no digit steps: done pulses in the
// next cycle and busy never rises. Every later tick holds busy high while it steps through the
// 4-bit digits of the 32-bit time values, least significant digit first; done pulses in the
// cycle after the last digit, when the next item may already be taken. The elapsed-time
// digit and all timer lanes advance together, each lane with its own 4-bit adder and
// 4-bit compare, and counts, periods, the reference time and the counter period rotate
// through shift registers. Results cannot be held off: done, fired_mask and time_primed
// are valid for exactly one cycle. counter_period may be written only while busy is low.
module multi_channel_interval_timer_bank
  import mcitb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic [IDX_W-1:0]    timer_index,
  input  logic [TIME_W-1:0]   period_us,
  input  logic                repeat_req,
  input  logic                enable_now,
  input  logic [TIME_W-1:0]   counter_reading,
  input  logic                wrapped,
  input  logic                cfg_we,
  input  logic [TIME_W-1:0]   cfg_wdata,
  output logic                done,
  output logic [MASK_W-1:0]   fired_mask,
  output logic                time_primed
);

  state_t state, state_next;

  logic [DCNT_W-1:0] dcnt;
  logic              pending;
  logic              wrap_q;
  logic              c1, c2;

  logic [TIME_W-1:0] rd_sr;
  logic [TIME_W-1:0] prev_sr;
  logic [TIME_W-1:0] cp_sr;

  logic [TIME_W-1:0] cnt_sr [NUM_TIMERS];
  logic [TIME_W-1:0] per_sr [NUM_TIMERS];
  logic              cont   [NUM_TIMERS];
  logic              en     [NUM_TIMERS];
  logic              ca     [NUM_TIMERS];
  logic              cb     [NUM_TIMERS];

  logic               accept;
  logic               run;
  logic               last;

  logic [DIGIT_W-1:0] now_d;
  logic [DIGIT_W-1:0] a_d;
  logic [DIGIT_W:0]   t5;
  logic [DIGIT_W:0]   u5;
  logic [DIGIT_W-1:0] delta_d;

  logic [DIGIT_W-1:0] s_d  [NUM_TIMERS];
  logic               ca_n [NUM_TIMERS];
  logic               cb_n [NUM_TIMERS];
  logic               fire [NUM_TIMERS];
  logic [MASK_W-1:0]  mask_c;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_TICK && !pending) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (dcnt == DCNT_W'(NUM_DIGITS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b0;
    run  = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        run  = 1'b0;
      end
      ST_RUN: begin
        busy = 1'b1;
        run  = 1'b1;
      end
      default: begin
        busy = 1'b0;
        run  = 1'b0;
      end
    endcase
  end

  assign last = run && (dcnt == DCNT_W'(NUM_DIGITS - 1));

  // elapsed-time digit: now - prev, or period - prev + now after a wrap
  always_comb begin
    now_d   = ~rd_sr[DIGIT_W-1:0];
    a_d     = wrap_q ? cp_sr[DIGIT_W-1:0] : now_d;
    t5      = {1'b0, a_d} + {1'b0, ~prev_sr[DIGIT_W-1:0]} + {{DIGIT_W{1'b0}}, c1};
    u5      = {1'b0, t5[DIGIT_W-1:0]} + {1'b0, now_d} + {{DIGIT_W{1'b0}}, c2};
    delta_d = wrap_q ? u5[DIGIT_W-1:0] : t5[DIGIT_W-1:0];
  end

  // one lane per timer: add the delta digit, then compare against the period digit
  always_comb begin
    logic [DIGIT_W:0] sum5;
    logic [DIGIT_W:0] dif5;
    mask_c = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      sum5    = {1'b0, cnt_sr[t][DIGIT_W-1:0]} + {1'b0, delta_d}
              + {{DIGIT_W{1'b0}}, ca[t]};
      s_d[t]  = sum5[DIGIT_W-1:0];
      ca_n[t] = sum5[DIGIT_W];
      dif5    = {1'b0, sum5[DIGIT_W-1:0]} + {1'b0, ~per_sr[t][DIGIT_W-1:0]}
              + {{DIGIT_W{1'b0}}, cb[t]};
      cb_n[t] = dif5[DIGIT_W];
      // a carry out counts as reaching the period, as a saturated count would
      fire[t] = en[t] && (ca_n[t] || cb_n[t]);
    end
    for (int b = 0; b < MASK_W; b++) begin
      if (b < NUM_TIMERS) begin
        mask_c[b] = fire[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      dcnt        <= '0;
      pending     <= 1'b1;
      done        <= 1'b0;
      fired_mask  <= '0;
      time_primed <= 1'b0;
      prev_sr     <= '0;
      cp_sr       <= COUNTER_PERIOD_RESET;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        cnt_sr[t] <= '0;
        per_sr[t] <= '0;
        cont[t]   <= 1'b0;
        en[t]     <= 1'b0;
      end
    end else begin
      state <= state_next;
      done  <= 1'b0;

      if (accept) begin
        case (mode)
          MODE_TICK: begin
            if (pending) begin
              prev_sr     <= ~counter_reading;
              pending     <= 1'b0;
              done        <= 1'b1;
              fired_mask  <= '0;
              time_primed <= 1'b1;
            end else begin
              rd_sr  <= counter_reading;
              wrap_q <= wrapped;
              c1     <= 1'b1;
              c2     <= 1'b0;
              dcnt   <= '0;
              for (int t = 0; t < NUM_TIMERS; t++) begin
                ca[t] <= 1'b0;
                cb[t] <= 1'b1;
              end
            end
          end
          MODE_SET, MODE_START, MODE_STOP: begin
            if (int'(timer_index) < NUM_TIMERS) begin
              cnt_sr[timer_index] <= '0;
              if (mode == MODE_SET) begin
                per_sr[timer_index] <= period_us;
                cont[timer_index]   <= repeat_req;
                en[timer_index]     <= enable_now;
              end else begin
                en[timer_index] <= (mode == MODE_START);
              end
            end
            done        <= 1'b1;
            fired_mask  <= '0;
            time_primed <= 1'b0;
          end
          default: begin
            done <= 1'b1;
          end
        endcase
      end

      if (run) begin
        dcnt    <= dcnt + 1'b1;
        c1      <= t5[DIGIT_W];
        c2      <= u5[DIGIT_W];
        rd_sr   <= rd_sr >> DIGIT_W;
        prev_sr <= {now_d, prev_sr[TIME_W-1:DIGIT_W]};
        cp_sr   <= {cp_sr[DIGIT_W-1:0], cp_sr[TIME_W-1:DIGIT_W]};
        for (int t = 0; t < NUM_TIMERS; t++) begin
          ca[t]     <= ca_n[t];
          cb[t]     <= cb_n[t];
          per_sr[t] <= {per_sr[t][DIGIT_W-1:0], per_sr[t][TIME_W-1:DIGIT_W]};
          if (en[t]) begin
            cnt_sr[t] <= {s_d[t], cnt_sr[t][TIME_W-1:DIGIT_W]};
          end else begin
            cnt_sr[t] <= {cnt_sr[t][DIGIT_W-1:0], cnt_sr[t][TIME_W-1:DIGIT_W]};
          end
          if (last && fire[t]) begin
            cnt_sr[t] <= '0;
            if (!cont[t]) begin
              en[t] <= 1'b0;
            end
          end
        end
        if (last) begin
          done        <= 1'b1;
          fired_mask  <= mask_c;
          time_primed <= 1'b0;
        end
      end

      if (cfg_we) begin
        cp_sr <= cfg_wdata;
      end
    end
  end

`include "multi_channel_interval_timer_bank_assert.svh"

  // a result only follows an accepted item or the last digit of a tick
  `MCITB_ASSERT(a_done_source, done |-> $past(accept || last), "result without a cause")
  // the block is never busy while a result is shown
  `MCITB_ASSERT(a_done_idle, done |-> !busy, "result shown while busy")
  // a priming result carries no fired timers
  `MCITB_ASSERT(a_primed_mask, (done && time_primed) |-> (fired_mask == '0),
                "priming result with fired timers")
  // the digit counter starts every tick at zero
  `MCITB_ASSERT_ALWAYS(a_run_start, (!rst && $rose(run)) |-> (dcnt == '0),
                       "tick started at a nonzero digit")

endmodule

/* sim/multi_channel_interval_timer_bank_test.sv */
// self-checking testbench for the interval timer bank: directed table, then random items
module multi_channel_interval_timer_bank_test;
  import mcitb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int SEG_ITEMS = 80;
  localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  timer_index;
    logic [TIME_W-1:0] period_us;
    logic              repeat_req;
    logic              enable_now;
    logic [TIME_W-1:0] counter_reading;
    logic              wrapped;
  } timer_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    logic              time_primed;
  } timer_result_t;

  typedef struct packed {
    timer_item_t   item;
    logic          typed_known;
    timer_result_t typed;
  } dir_row_t;

  localparam int DIR_ROWS = 20;

  // typed results only for non-tick items and the priming tick
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{'{MODE_TICK,  3'd0, ALL_ONES,      1'b1, 1'b1, ALL_ONES,      1'b1}, 1'b1, '{8'h00, 1'b1}},
    '{'{MODE_SET,   3'd0, 32'd0,         1'b1, 1'b1, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_SET,   3'd7, ALL_ONES,      1'b0, 1'b1, ALL_ONES,      1'b1}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_SET,   3'd1, 32'd100,       1'b0, 1'b1, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd0, 32'd0,         1'b0, 1'b0, 32'hFFFFFFCD,  1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd5, 32'd0,         1'b0, 1'b0, 32'hFFFFFF69,  1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{MODE_START, 3'd1, 32'd0,         1'b0, 1'b0, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_STOP,  3'd0, ALL_ONES,      1'b1, 1'b1, ALL_ONES,      1'b1}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_SET,   3'd2, 32'd10,        1'b1, 1'b0, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_START, 3'd2, 32'd0,         1'b0, 1'b0, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd0, 32'd0,         1'b0, 1'b0, 32'd0,         1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd0, 32'd0,         1'b0, 1'b0, ALL_ONES,      1'b1}, 1'b0, '{8'h00, 1'b0}},
    '{'{MODE_SET,   3'd3, ALL_ONES,      1'b1, 1'b1, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd0, 32'd0,         1'b0, 1'b0, 32'h7FFFFFFF,  1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd0, 32'd0,         1'b0, 1'b0, 32'd0,         1'b1}, 1'b0, '{8'h00, 1'b0}},
    '{'{MODE_SET,   3'd4, 32'd5,         1'b0, 1'b1, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd0, 32'd0,         1'b0, 1'b0, 32'hFFFFFFF0,  1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{MODE_STOP,  3'd7, 32'd0,         1'b0, 1'b0, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_START, 3'd7, 32'd0,         1'b0, 1'b0, 32'd0,         1'b0}, 1'b1, '{8'h00, 1'b0}},
    '{'{MODE_TICK,  3'd6, 32'd0,         1'b1, 1'b1, 32'hFFFFFFE0,  1'b0}, 1'b0, '{8'h00, 1'b0}}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        mode = MODE_TICK;
  logic [IDX_W-1:0]  timer_index = '0;
  logic [TIME_W-1:0] period_us = '0;
  logic              repeat_req = 1'b0;
  logic              enable_now = 1'b0;
  logic [TIME_W-1:0] counter_reading = '0;
  logic              wrapped = 1'b0;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;
  logic              done;
  logic [MASK_W-1:0] fired_mask;
  logic              time_primed;

  // predicted timer bank state
  logic [TIME_W-1:0] timer_count  [NUM_TIMERS];
  logic [TIME_W-1:0] timer_period [NUM_TIMERS];
  logic              timer_cont   [NUM_TIMERS];
  logic              timer_en     [NUM_TIMERS];
  logic [TIME_W-1:0] ref_time;
  logic              prime_pending;
  logic [TIME_W-1:0] cnt_period;

  timer_result_t awaited_fires [$];
  timer_result_t oldest_fire;
  int            mismatch_count = 0;
  int            stall_cycles = 0;
  logic [TIME_W-1:0] stim_now;

  multi_channel_interval_timer_bank u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .timer_index     (timer_index),
    .period_us       (period_us),
    .repeat_req      (repeat_req),
    .enable_now      (enable_now),
    .counter_reading (counter_reading),
    .wrapped         (wrapped),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .done            (done),
    .fired_mask      (fired_mask),
    .time_primed     (time_primed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  function automatic timer_result_t advance_timers(input timer_item_t it);
    timer_result_t     r;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delta;
    logic [TIME_W:0]   sum;
    r = '0;
    if (it.mode == MODE_TICK) begin
      now = ALL_ONES - it.counter_reading;
      if (prime_pending) begin
        ref_time = now;
        prime_pending = 1'b0;
        r.time_primed = 1'b1;
      end else begin
        delta = it.wrapped ? cnt_period - ref_time + now : now - ref_time;
        ref_time = now;
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (timer_en[t]) begin
            sum = {1'b0, timer_count[t]} + {1'b0, delta};
            timer_count[t] = sum[TIME_W] ? ALL_ONES : sum[TIME_W-1:0];
            if (timer_count[t] >= timer_period[t]) begin
              if (t < MASK_W) r.fired_mask[t] = 1'b1;
              if (!timer_cont[t]) timer_en[t] = 1'b0;
              timer_count[t] = '0;
            end
          end
        end
      end
    end else if (it.timer_index < NUM_TIMERS) begin
      timer_count[it.timer_index] = '0;
      case (it.mode)
        MODE_SET: begin
          timer_period[it.timer_index] = it.period_us;
          timer_cont[it.timer_index] = it.repeat_req;
          timer_en[it.timer_index] = it.enable_now;
        end
        MODE_START: timer_en[it.timer_index] = 1'b1;
        default: timer_en[it.timer_index] = 1'b0;
      endcase
    end
    return r;
  endfunction

  // start stays high into the next item unless an idle gap is taken
  task automatic send_item(input timer_item_t it, input bit use_typed,
                           input timer_result_t typed, input int idle_pct);
    timer_result_t predicted;
    start <= 1'b1;
    mode <= it.mode;
    timer_index <= it.timer_index;
    period_us <= it.period_us;
    repeat_req <= it.repeat_req;
    enable_now <= it.enable_now;
    counter_reading <= it.counter_reading;
    wrapped <= it.wrapped;
    do @(posedge clk); while (busy);
    predicted = advance_timers(it);
    awaited_fires.push_back(use_typed ? typed : predicted);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_counter_period(input logic [TIME_W-1:0] value);
    start <= 1'b0;
    while (awaited_fires.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cnt_period = value;
  endtask

  task automatic run_random_segment(input int n, input int idle_pct);
    timer_item_t it;
    int          pick;
    for (int i = 0; i < n; i++) begin
      // unused fields carry noise
      it.timer_index = IDX_W'($urandom_range(0, NUM_TIMERS - 1));
      it.period_us = $urandom;
      it.repeat_req = 1'($urandom_range(0, 1));
      it.enable_now = 1'($urandom_range(0, 1));
      it.counter_reading = $urandom;
      it.wrapped = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it.mode = MODE_TICK;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          stim_now = stim_now + $urandom_range(0, 3000);
          it.wrapped = 1'b0;
        end else if (pick < 90) begin
          stim_now = $urandom_range(0, 5000);
          it.wrapped = 1'b1;
        end else begin
          stim_now = $urandom;
        end
        it.counter_reading = ~stim_now;
      end else if (pick < 70) begin
        it.mode = MODE_SET;
        pick = $urandom_range(0, 99);
        if (pick < 70) it.period_us = $urandom_range(0, 4000);
        else if (pick < 80) it.period_us = '0;
        else if (pick < 90) it.period_us = ALL_ONES;
      end else if (pick < 85) begin
        it.mode = MODE_START;
      end else begin
        it.mode = MODE_STOP;
      end
      send_item(it, 1'b0, '0, idle_pct);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_fires.size() == 0) begin
        report_mismatch("result with nothing awaited", {24'd0, fired_mask}, '0);
      end else begin
        oldest_fire = awaited_fires.pop_front();
        if (fired_mask !== oldest_fire.fired_mask)
          report_mismatch("fired_mask", {24'd0, fired_mask}, {24'd0, oldest_fire.fired_mask});
        if (time_primed !== oldest_fire.time_primed)
          report_mismatch("time_primed", {31'd0, time_primed}, {31'd0, oldest_fire.time_primed});
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int t = 0; t < NUM_TIMERS; t++) begin
      timer_count[t] = '0;
      timer_period[t] = '0;
      timer_cont[t] = 1'b0;
      timer_en[t] = 1'b0;
    end
    ref_time = '0;
    prime_pending = 1'b1;
    cnt_period = COUNTER_PERIOD_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].item, dir_rows[i].typed_known, dir_rows[i].typed, 21);
    stim_now = 32'h1F;

    run_random_segment(SEG_ITEMS, 21);
    write_counter_period('0);
    run_random_segment(SEG_ITEMS, 21);
    write_counter_period(32'd1);
    run_random_segment(SEG_ITEMS, 51);
    write_counter_period(ALL_ONES);
    run_random_segment(SEG_ITEMS, 51);
    write_counter_period($urandom);
    run_random_segment(SEG_ITEMS, 0);
    write_counter_period($urandom_range(1, 100000));
    run_random_segment(SEG_ITEMS, 0);

    start <= 1'b0;
    while (awaited_fires.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_fires.size() != 0)
      report_mismatch("results never arrived", awaited_fires.size(), '0);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/mcitb_pkg.sv
src/multi_channel_interval_timer_bank.sv
sim/multi_channel_interval_timer_bank_test.sv
